[hdl/covalent_bond_pair_detector_macros.svh]
// Assertion helpers shared by the checker.
`ifndef COVALENT_BOND_PAIR_DETECTOR_MACROS_SVH
`define COVALENT_BOND_PAIR_DETECTOR_MACROS_SVH

// same-cycle implication, gated by reset
`define BCPD_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("bcpd assertion failed");

// next-cycle implication, gated by reset
`define BCPD_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("bcpd assertion failed");

`endif

[hdl/bcpd_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package bcpd_pkg;

    localparam int MAX_ATOMS_DEF = 64;

    localparam int POS_W      = 20;
    localparam int RAD_W      = 10;
    localparam int OUT_IDX_W  = 6;
    localparam int MIN_W      = 16;
    localparam int DIFF_W     = POS_W + 1;
    localparam int SQ_W       = 2 * DIFF_W;
    localparam int D2_W       = SQ_W + 2;
    localparam int LIM_W      = RAD_W + 2;
    localparam int LIM_SQ_W   = 2 * LIM_W;

    localparam int S_TDATA_W  = 72;
    localparam int M_TDATA_W  = 16;
    localparam int M_TUSER_W  = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [RAD_W-1:0] TOL_RESET  = 10'd102;
    localparam logic [RAD_W-1:0] DRAD_RESET = 10'd179;
    localparam logic [MIN_W-1:0] MIN_RESET  = 16'd1;

    localparam logic CMD_CLEAR = 1'b0;
    localparam logic CMD_ADD   = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_BOND_TOL = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DEF_RAD  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_DSQ  = 2'd2;

    typedef struct packed {
        logic signed [POS_W-1:0] x;
        logic signed [POS_W-1:0] y;
        logic signed [POS_W-1:0] z;
        logic [RAD_W-1:0]        r;
    } atom_t;

    // cand: bond candidate (becomes is_bond), otherwise an end marker
    typedef struct packed {
        logic                 valid;
        logic                 cand;
        logic                 ovf;
        logic [OUT_IDX_W-1:0] first;
        logic [OUT_IDX_W-1:0] second;
    } tok_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_STORE,
        ST_MARK
    } state_t;

endpackage
`default_nettype wire

[hdl/bcpd_cell.sv]
`timescale 1ns / 1ps
`default_nettype none
module bcpd_cell (
    input  wire logic              aclk,
    input  wire logic              shift_en,
    input  wire logic              load_en,
    input  wire bcpd_pkg::atom_t   shift_in,
    input  wire bcpd_pkg::atom_t   load_data,
    output bcpd_pkg::atom_t        atom_q
);
    import bcpd_pkg::*;

    atom_t atom_reg;

    always_ff @(posedge aclk) begin
        if (load_en) begin
            atom_reg <= load_data;
        end else if (shift_en) begin
            atom_reg <= shift_in;
        end
    end

    assign atom_q = atom_reg;

endmodule
`default_nettype wire

[hdl/bcpd_dist.sv]
`timescale 1ns / 1ps
`default_nettype none
module bcpd_dist (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        en,
    input  wire bcpd_pkg::tok_t              tok_in,
    input  wire bcpd_pkg::atom_t             probe,
    input  wire bcpd_pkg::atom_t             head,
    input  wire logic [bcpd_pkg::RAD_W-1:0]  bond_tol,
    input  wire logic [bcpd_pkg::MIN_W-1:0]  min_dsq,
    output bcpd_pkg::tok_t                   res
);
    import bcpd_pkg::*;

    function automatic logic [DIFF_W-1:0] abs_diff(input logic signed [POS_W-1:0] a,
                                                   input logic signed [POS_W-1:0] b);
        logic signed [DIFF_W-1:0] d;
        d = DIFF_W'(a) - DIFF_W'(b);
        return d[DIFF_W-1] ? DIFF_W'(-d) : DIFF_W'(d);
    endfunction

    tok_t tok1_reg, tok2_reg, tok3_reg, tok4_reg;

    logic [DIFF_W-1:0]   ax_reg, ay_reg, az_reg;
    logic [LIM_W-1:0]    lim_reg;
    logic [SQ_W-1:0]     sx_reg, sy_reg, sz_reg;
    logic [LIM_SQ_W-1:0] lim2_reg, lim2_d_reg;
    logic [D2_W-1:0]     d2_reg;
    logic                hit;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tok1_reg.valid <= 1'b0;
            tok2_reg.valid <= 1'b0;
            tok3_reg.valid <= 1'b0;
            tok4_reg.valid <= 1'b0;
        end else if (en) begin
            tok1_reg.valid <= tok_in.valid;
            tok2_reg.valid <= tok1_reg.valid;
            tok3_reg.valid <= tok2_reg.valid;
            // candidates that miss are dropped here
            tok4_reg.valid <= tok3_reg.valid && (!tok3_reg.cand || hit);
        end

        if (en) begin
            tok1_reg.cand   <= tok_in.cand;
            tok1_reg.ovf    <= tok_in.ovf;
            tok1_reg.first  <= tok_in.first;
            tok1_reg.second <= tok_in.second;
            tok2_reg.cand   <= tok1_reg.cand;
            tok2_reg.ovf    <= tok1_reg.ovf;
            tok2_reg.first  <= tok1_reg.first;
            tok2_reg.second <= tok1_reg.second;
            tok3_reg.cand   <= tok2_reg.cand;
            tok3_reg.ovf    <= tok2_reg.ovf;
            tok3_reg.first  <= tok2_reg.first;
            tok3_reg.second <= tok2_reg.second;
            tok4_reg.cand   <= tok3_reg.cand;
            tok4_reg.ovf    <= tok3_reg.ovf;
            tok4_reg.first  <= tok3_reg.first;
            tok4_reg.second <= tok3_reg.second;

            ax_reg  <= abs_diff(probe.x, head.x);
            ay_reg  <= abs_diff(probe.y, head.y);
            az_reg  <= abs_diff(probe.z, head.z);
            lim_reg <= LIM_W'(probe.r) + LIM_W'(head.r) + LIM_W'(bond_tol);

            sx_reg   <= SQ_W'(ax_reg) * SQ_W'(ax_reg);
            sy_reg   <= SQ_W'(ay_reg) * SQ_W'(ay_reg);
            sz_reg   <= SQ_W'(az_reg) * SQ_W'(az_reg);
            lim2_reg <= LIM_SQ_W'(lim_reg) * LIM_SQ_W'(lim_reg);

            d2_reg     <= D2_W'(sx_reg) + D2_W'(sy_reg) + D2_W'(sz_reg);
            lim2_d_reg <= lim2_reg;
        end
    end

    assign hit = (d2_reg > D2_W'(min_dsq)) && (d2_reg <= D2_W'(lim2_d_reg));
    assign res = tok4_reg;

endmodule
`default_nettype wire

[hdl/covalent_bond_pair_detector.sv]
// Covalent bond pair detector.
// s_ channel: one word per command. tuser[0] = command (clear / add atom),
// tdata carries the atom position and covalent radius.
// m_ channel: one word per bonded pair (tuser[0] = 1) in ascending store index,
// then one end marker with tlast high; tuser[1] flags an atom dropped on a full
// store. cfg_ channel writes bond tolerance, default radius and minimum
// squared distance; it is always ready, and the user must write it only while
// the block is idle, which the block does not enforce. Stored atoms sit in a
// ring of MAX_ATOMS cells that rotates one place per cycle past one distance
// unit. An add to a non-empty store scans every cell, then stores the atom; an
// add to an empty store stores it at once, and a clear or a drop gives its
// marker; s_tready returns when that step ends. Results pass the distance
// pipeline: differences, squares, squared sum, then the bond test. A stall on
// m_tready freezes the ring, the pipeline and the output word. Reset empties
// the store and restores the register defaults; no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none
module covalent_bond_pair_detector #(
    parameter int MAX_ATOMS = bcpd_pkg::MAX_ATOMS_DEF
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             s_tvalid,
    output      logic                             s_tready,
    // pos_x, pos_y, pos_z, cov_radius, zero pad
    input  wire logic [bcpd_pkg::S_TDATA_W-1:0]   s_tdata,
    // command
    input  wire logic [0:0]                       s_tuser,
    output      logic                             m_tvalid,
    input  wire logic                             m_tready,
    // first_index, second_index, zero pad
    output      logic [bcpd_pkg::M_TDATA_W-1:0]   m_tdata,
    // is_bond, overflow
    output      logic [bcpd_pkg::M_TUSER_W-1:0]   m_tuser,
    output      logic                             m_tlast,
    input  wire logic                             cfg_valid,
    output      logic                             cfg_ready,
    input  wire logic [bcpd_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [bcpd_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import bcpd_pkg::*;

    localparam int IDX_W = $clog2(MAX_ATOMS);
    localparam int CNT_W = $clog2(MAX_ATOMS + 1);
    localparam logic [IDX_W-1:0] LAST_STEP = IDX_W'(MAX_ATOMS - 1);

    state_t state_reg, state_next;
    logic [IDX_W-1:0] step_reg, step_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             mark_ovf_reg;
    atom_t            probe_reg;
    logic [RAD_W-1:0] tol_reg, drad_reg;
    logic [MIN_W-1:0] min_reg;

    logic  accept, full, en, shift_en, store_fire;
    logic  in_cmd;
    atom_t in_atom;
    tok_t  tok_in, res;
    atom_t cell_q [MAX_ATOMS];

    assign accept = s_tvalid && s_tready;
    assign full   = count_reg == CNT_W'(MAX_ATOMS);
    assign en     = !res.valid || m_tready;
    assign in_cmd = s_tuser[0];

    always_comb begin
        in_atom.x = s_tdata[19:0];
        in_atom.y = s_tdata[39:20];
        in_atom.z = s_tdata[59:40];
        in_atom.r = (s_tdata[69:60] == '0) ? drad_reg : s_tdata[69:60];
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (in_cmd == CMD_ADD && !full) begin
                        state_next = (count_reg == '0) ? ST_STORE : ST_SCAN;
                    end else begin
                        state_next = ST_MARK;
                    end
                end
            end
            ST_SCAN: begin
                if (en && step_reg == LAST_STEP) begin
                    state_next = ST_STORE;
                end
            end
            ST_STORE, ST_MARK: begin
                if (en) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        s_tready      = 1'b0;
        shift_en      = 1'b0;
        store_fire    = 1'b0;
        tok_in.valid  = 1'b0;
        tok_in.cand   = 1'b0;
        tok_in.ovf    = 1'b0;
        tok_in.first  = '0;
        tok_in.second = '0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
            end
            ST_SCAN: begin
                shift_en      = en;
                tok_in.valid  = CNT_W'(step_reg) < count_reg;
                tok_in.cand   = 1'b1;
                tok_in.first  = OUT_IDX_W'(step_reg);
                tok_in.second = OUT_IDX_W'(count_reg);
            end
            ST_STORE: begin
                store_fire    = en;
                tok_in.valid  = 1'b1;
                tok_in.second = OUT_IDX_W'(count_reg);
            end
            ST_MARK: begin
                tok_in.valid = 1'b1;
                tok_in.ovf   = mark_ovf_reg;
            end
            default: ;
        endcase
    end

    always_comb begin
        step_next = step_reg;
        if (shift_en) begin
            step_next = (step_reg == LAST_STEP) ? '0 : step_reg + 1'b1;
        end
    end

    always_comb begin
        count_next = count_reg;
        if (accept && in_cmd == CMD_CLEAR) begin
            count_next = '0;
        end else if (store_fire) begin
            count_next = count_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            step_reg     <= '0;
            count_reg    <= '0;
            mark_ovf_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            step_reg  <= step_next;
            count_reg <= count_next;
            if (accept) begin
                // a marker from an add command means the store was full
                mark_ovf_reg <= in_cmd == CMD_ADD;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            probe_reg <= in_atom;
        end
    end

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tol_reg  <= TOL_RESET;
            drad_reg <= DRAD_RESET;
            min_reg  <= MIN_RESET;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                CFG_BOND_TOL: tol_reg  <= cfg_data[RAD_W-1:0];
                CFG_DEF_RAD:  drad_reg <= cfg_data[RAD_W-1:0];
                CFG_MIN_DSQ:  min_reg  <= cfg_data[MIN_W-1:0];
                default: ;
            endcase
        end
    end

    // ring of stored atoms; cell 0 faces the distance unit
    for (genvar i = 0; i < MAX_ATOMS; i++) begin : g_cell
        localparam int NEXT = (i + 1) % MAX_ATOMS;
        bcpd_cell u_cell (
            .aclk      (aclk),
            .shift_en  (shift_en),
            .load_en   (store_fire && count_reg == CNT_W'(i)),
            .shift_in  (cell_q[NEXT]),
            .load_data (probe_reg),
            .atom_q    (cell_q[i])
        );
    end

    bcpd_dist u_dist (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .tok_in   (tok_in),
        .probe    (probe_reg),
        .head     (cell_q[0]),
        .bond_tol (tol_reg),
        .min_dsq  (min_reg),
        .res      (res)
    );

    assign m_tvalid = res.valid;
    assign m_tdata  = {{(M_TDATA_W - 2*OUT_IDX_W){1'b0}}, res.second, res.first};
    assign m_tuser  = {res.ovf, res.cand};
    assign m_tlast  = !res.cand;

endmodule
`default_nettype wire

[hdl/bcpd_checker.sv]
`timescale 1ns / 1ps
`default_nettype none
`include "covalent_bond_pair_detector_macros.svh"
module bcpd_checker (
    input wire logic                            aclk,
    input wire logic                            aresetn,
    input wire logic                            s_tvalid,
    input wire logic                            s_tready,
    input wire logic                            m_tvalid,
    input wire logic                            m_tready,
    input wire logic [bcpd_pkg::M_TDATA_W-1:0]  m_tdata,
    input wire logic [bcpd_pkg::M_TUSER_W-1:0]  m_tuser,
    input wire logic                            m_tlast
);
    import bcpd_pkg::*;

    // a stalled word holds
    `BCPD_ASSERT_NXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast))

    // a bond word never closes a command
    `BCPD_ASSERT_IMP(a_bond_not_last, m_tvalid && m_tuser[0], !m_tlast)

    // a dropped atom gives a bare marker with zero indexes
    `BCPD_ASSERT_IMP(a_ovf_marker, m_tvalid && m_tuser[1], m_tlast && !m_tuser[0] && m_tdata == '0)

    // after each accepted command the input side is busy in the next cycle
    `BCPD_ASSERT_NXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready)

endmodule

bind covalent_bond_pair_detector bcpd_checker u_bcpd_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
`default_nettype wire
